>>> sv/vc3_pkg.sv
// Shared constants, types and helpers for the 3D convolution block.
// No dependencies; the files that use this package refer to it by scoped names.
`timescale 1ns / 1ps
package vc3_pkg;

    localparam int MAX_DIM_X      = 64;
    localparam int MAX_DIM_Y      = 64;
    localparam int MAX_DIM_Z      = 64;
    localparam int MAX_HALF_WIDTH = 3;

    localparam int KSPAN   = 2 * MAX_HALF_WIDTH + 1;
    localparam int KCOUNT  = KSPAN * KSPAN * KSPAN;
    localparam int VCOUNT  = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int KADDR_W = $clog2(KCOUNT);
    localparam int VADDR_W = $clog2(VCOUNT);
    localparam int KI_W    = $clog2(KSPAN);
    localparam int HW_W    = 2;
    localparam int POS_W   = 6;
    localparam int SMP_W   = 16;
    localparam int DIM_W   = 7;
    localparam int CW      = 11;
    localparam int OP_W    = 2;

    localparam int FRAC_W  = 14;
    localparam int PROD_W  = 2 * SMP_W;
    localparam int ACC_W   = PROD_W + $clog2(KCOUNT);
    localparam int WSUM_W  = SMP_W + $clog2(KCOUNT);
    localparam int DIVD_W  = ACC_W + FRAC_W;
    localparam int DIVS_W  = WSUM_W - 1;
    localparam int OUT_W   = 48;
    localparam int CNT_W   = $clog2(DIVD_W + 1);

    localparam logic [OP_W-1:0] OP_KERNEL = 2'd0;
    localparam logic [OP_W-1:0] OP_VOXEL  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] REG_NORMALIZE = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_DEPTH     = 3'd3;
    localparam logic [2:0] REG_HALF_X    = 3'd4;
    localparam logic [2:0] REG_HALF_Y    = 3'd5;
    localparam logic [2:0] REG_HALF_Z    = 3'd6;

    localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] quotient;
    } div_res_t;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > OUT_MAX) r = OUT_MAX;
        if (v < OUT_MIN) r = OUT_MIN;
        return r[OUT_W-1:0];
    endfunction

endpackage

>>> sv/vc3_if.sv
// Handshake channels for the 3D convolution block: input item and result.
// Depends on vc3_pkg for field widths.
`timescale 1ns / 1ps
interface vc3_in_if;
    logic                              valid;
    logic                              ready;
    logic [vc3_pkg::OP_W-1:0]          opcode;
    logic [vc3_pkg::POS_W-1:0]         pos_x;
    logic [vc3_pkg::POS_W-1:0]         pos_y;
    logic [vc3_pkg::POS_W-1:0]         pos_z;
    logic signed [vc3_pkg::SMP_W-1:0]  sample;

    modport source (output valid, opcode, pos_x, pos_y, pos_z, sample, input ready);
    modport sink   (input valid, opcode, pos_x, pos_y, pos_z, sample, output ready);
endinterface

interface vc3_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [vc3_pkg::OUT_W-1:0]  filtered;
    logic                              weight_sum_not_positive;

    modport source (output valid, filtered, weight_sum_not_positive, input ready);
    modport sink   (input valid, filtered, weight_sum_not_positive, output ready);
endinterface

>>> sv/vc3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vc3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/vc3_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// result saturated to the output range. Depends on vc3_pkg.
`timescale 1ns / 1ps
module vc3_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [vc3_pkg::ACC_W-1:0]  acc,
    input  logic [vc3_pkg::DIVS_W-1:0]        divisor,
    output vc3_pkg::div_res_t                 res
);
    localparam int DW = vc3_pkg::DIVD_W;
    localparam int SW = vc3_pkg::DIVS_W;

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic [vc3_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]     quo_reg, quo_next;
    logic [SW:0]       rem_reg, rem_next;
    logic [SW-1:0]     dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [SW+1:0]     shifted;
    logic [SW+1:0]     trial;
    logic signed [63:0] signed_q;
    logic [DW-1:0]     mag;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = shifted - {2'b00, dvs_reg};
        mag       = '0;
        if (start)
        begin
            mag       = acc[vc3_pkg::ACC_W-1] ? DW'(-acc) : DW'(acc);
            quo_next  = mag << vc3_pkg::FRAC_W;
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = acc[vc3_pkg::ACC_W-1];
            cnt_next  = vc3_pkg::CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SW+1])
            begin
                rem_next = trial[SW:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SW:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == vc3_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // quotient magnitude fits in DW bits, well inside 64
    assign signed_q = neg_reg ? -$signed(64'(quo_reg)) : $signed(64'(quo_reg));
    assign res.done     = fin_reg;
    assign res.quotient = vc3_pkg::sat_out(signed_q);
endmodule

>>> sv/volume_convolution_3d.sv
// Normalised 3D convolution: voxel and kernel RAMs, tap sequencer, MAC, divider.
// A query walks (2rx+1)(2ry+1)(2rz+1) taps, then drains the pipeline
// (voxel/kernel RAM read, multiply, accumulate), then divides when normalising
// (serial divider, one quotient bit per cycle).
// One item in flight at a time; input held off until the result is taken.
// rst_n (async, active low) resets control and configuration to defaults; RAMs are not cleared.
`timescale 1ns / 1ps
module volume_convolution_3d (
    input  logic                clk,
    input  logic                rst_n,
    vc3_in_if.sink              in_ch,
    vc3_out_if.source           out_ch,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [vc3_pkg::DIM_W-1:0] cfg_data
);
    localparam int CW  = vc3_pkg::CW;
    localparam int KW  = vc3_pkg::KI_W;
    localparam int HW  = vc3_pkg::HW_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_OUTPUT = 3'd4;

    logic [2:0] state_reg, state_next;

    // configuration
    logic                       norm_reg;
    logic [vc3_pkg::DIM_W-1:0]  vw_reg, vh_reg, vd_reg;
    logic [HW-1:0]              hx_reg, hy_reg, hz_reg;

    // query context
    logic [vc3_pkg::POS_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [KW-1:0]              kx_reg, ky_reg, kz_reg, kx_next, ky_next, kz_next;

    logic                       p1_valid_reg, p2_valid_reg;
    logic signed [vc3_pkg::PROD_W-1:0] prod_reg;
    logic signed [vc3_pkg::SMP_W-1:0]  wt_reg;
    logic signed [vc3_pkg::ACC_W-1:0]  acc_reg;
    logic signed [vc3_pkg::WSUM_W-1:0] wsum_reg;

    logic                       out_valid_reg;
    logic signed [vc3_pkg::OUT_W-1:0] out_data_reg, res_val;
    logic                       out_flag_reg, res_flag;

    logic                       accept, issue, last_tap, div_start;
    logic [CW-1:0]              w_eff, h_eff, d_eff;
    logic [KW-1:0]              rx2, ry2, rz2;
    logic [HW-1:0]              rx, ry, rz;
    logic signed [CW-1:0]       tx, ty, tz;
    logic                       inb;

    logic                       k_we, v_we;
    logic [vc3_pkg::KADDR_W-1:0] k_waddr, k_raddr;
    logic [vc3_pkg::VADDR_W-1:0] v_waddr, v_raddr;
    logic [vc3_pkg::SMP_W-1:0]  k_rdata, v_rdata;
    vc3_pkg::div_res_t          div_res;

    function automatic logic [CW-1:0] clamp_dim(input logic [vc3_pkg::DIM_W-1:0] v,
                                                 input int lim);
        logic [CW-1:0] r;
        r = CW'(v);
        if (r > CW'(lim)) r = CW'(lim);
        return r;
    endfunction

    function automatic logic [HW-1:0] clamp_half(input logic [HW-1:0] v);
        logic [HW-1:0] r;
        r = v;
        if (CW'(v) > CW'(vc3_pkg::MAX_HALF_WIDTH)) r = HW'(vc3_pkg::MAX_HALF_WIDTH);
        return r;
    endfunction

    function automatic logic [vc3_pkg::KADDR_W-1:0] kaddr(input logic [KW-1:0] x,
        input logic [KW-1:0] y, input logic [KW-1:0] z);
        return vc3_pkg::KADDR_W'((int'(z) * vc3_pkg::KSPAN + int'(y)) * vc3_pkg::KSPAN
                                 + int'(x));
    endfunction

    function automatic logic [vc3_pkg::VADDR_W-1:0] vaddr(input logic [CW-1:0] x,
        input logic [CW-1:0] y, input logic [CW-1:0] z);
        return vc3_pkg::VADDR_W'((int'(z) * vc3_pkg::MAX_DIM_Y + int'(y))
                                 * vc3_pkg::MAX_DIM_X + int'(x));
    endfunction

    assign w_eff = clamp_dim(vw_reg, vc3_pkg::MAX_DIM_X);
    assign h_eff = clamp_dim(vh_reg, vc3_pkg::MAX_DIM_Y);
    assign d_eff = clamp_dim(vd_reg, vc3_pkg::MAX_DIM_Z);
    assign rx = clamp_half(hx_reg);
    assign ry = clamp_half(hy_reg);
    assign rz = clamp_half(hz_reg);
    assign rx2 = KW'(rx) << 1;
    assign ry2 = KW'(ry) << 1;
    assign rz2 = KW'(rz) << 1;

    assign tx = $signed(CW'(cx_reg)) + $signed(CW'(kx_reg)) - $signed(CW'(rx));
    assign ty = $signed(CW'(cy_reg)) + $signed(CW'(ky_reg)) - $signed(CW'(ry));
    assign tz = $signed(CW'(cz_reg)) + $signed(CW'(kz_reg)) - $signed(CW'(rz));
    assign inb = !tx[CW-1] && !ty[CW-1] && !tz[CW-1]
                 && ($unsigned(tx) < w_eff) && ($unsigned(ty) < h_eff)
                 && ($unsigned(tz) < d_eff);

    assign last_tap = (kx_reg == rx2) && (ky_reg == ry2) && (kz_reg == rz2);
    assign issue    = (state_reg == ST_RUN) && inb;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // write side of both stores
    assign k_we = accept && (in_ch.opcode == vc3_pkg::OP_KERNEL)
                  && (CW'(in_ch.pos_x) < CW'(vc3_pkg::KSPAN))
                  && (CW'(in_ch.pos_y) < CW'(vc3_pkg::KSPAN))
                  && (CW'(in_ch.pos_z) < CW'(vc3_pkg::KSPAN));
    assign v_we = accept && (in_ch.opcode == vc3_pkg::OP_VOXEL)
                  && (CW'(in_ch.pos_x) < CW'(vc3_pkg::MAX_DIM_X))
                  && (CW'(in_ch.pos_y) < CW'(vc3_pkg::MAX_DIM_Y))
                  && (CW'(in_ch.pos_z) < CW'(vc3_pkg::MAX_DIM_Z));
    assign k_waddr = kaddr(KW'(in_ch.pos_x), KW'(in_ch.pos_y), KW'(in_ch.pos_z));
    assign v_waddr = vaddr(CW'(in_ch.pos_x), CW'(in_ch.pos_y), CW'(in_ch.pos_z));
    assign k_raddr = kaddr(kx_reg, ky_reg, kz_reg);
    assign v_raddr = vaddr($unsigned(tx), $unsigned(ty), $unsigned(tz));

    vc3_ram #(.WIDTH(vc3_pkg::SMP_W), .DEPTH(vc3_pkg::KCOUNT)) u_kernel_ram (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(in_ch.sample),
        .re(issue), .raddr(k_raddr), .rdata(k_rdata)
    );

    vc3_ram #(.WIDTH(vc3_pkg::SMP_W), .DEPTH(vc3_pkg::VCOUNT)) u_voxel_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(in_ch.sample),
        .re(issue), .raddr(v_raddr), .rdata(v_rdata)
    );

    vc3_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .acc(acc_reg),
        .divisor(vc3_pkg::DIVS_W'(wsum_reg)), .res(div_res)
    );

    // tap walk: x fastest, then y, then z
    always_comb
    begin
        kx_next = kx_reg + 1'b1;
        ky_next = ky_reg;
        kz_next = kz_reg;
        if (kx_reg == rx2)
        begin
            kx_next = '0;
            ky_next = ky_reg + 1'b1;
            if (ky_reg == ry2)
            begin
                ky_next = '0;
                kz_next = kz_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        res_val    = vc3_pkg::sat_out(64'(acc_reg));
        res_flag   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_ch.opcode == vc3_pkg::OP_QUERY)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    if (norm_reg && wsum_reg > 0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_OUTPUT;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                // hold here until the result transaction completes
                if (out_valid_reg && out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (norm_reg)
        begin
            res_val  = '0;
            res_flag = (wsum_reg <= 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            norm_reg      <= 1'b0;
            vw_reg        <= vc3_pkg::DIM_W'(64);
            vh_reg        <= vc3_pkg::DIM_W'(64);
            vd_reg        <= vc3_pkg::DIM_W'(64);
            hx_reg        <= HW'(1);
            hy_reg        <= HW'(1);
            hz_reg        <= HW'(1);
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vc3_pkg::REG_NORMALIZE: norm_reg <= cfg_data[0];
                    vc3_pkg::REG_WIDTH:     vw_reg   <= cfg_data;
                    vc3_pkg::REG_HEIGHT:    vh_reg   <= cfg_data;
                    vc3_pkg::REG_DEPTH:     vd_reg   <= cfg_data;
                    vc3_pkg::REG_HALF_X:    hx_reg   <= cfg_data[HW-1:0];
                    vc3_pkg::REG_HALF_Y:    hy_reg   <= cfg_data[HW-1:0];
                    vc3_pkg::REG_HALF_Z:    hz_reg   <= cfg_data[HW-1:0];
                    default:                ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_OUTPUT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg   <= in_ch.pos_x;
            cy_reg   <= in_ch.pos_y;
            cz_reg   <= in_ch.pos_z;
            kx_reg   <= '0;
            ky_reg   <= '0;
            kz_reg   <= '0;
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_RUN)
            begin
                kx_reg <= kx_next;
                ky_reg <= ky_next;
                kz_reg <= kz_next;
            end
            if (p2_valid_reg)
            begin
                acc_reg  <= acc_reg + vc3_pkg::ACC_W'(prod_reg);
                wsum_reg <= wsum_reg + vc3_pkg::WSUM_W'(wt_reg);
            end
        end
        prod_reg <= $signed(k_rdata) * $signed(v_rdata);
        wt_reg   <= $signed(k_rdata);
        if (state_reg == ST_FINISH && !p1_valid_reg && !p2_valid_reg)
        begin
            out_data_reg <= res_val;
            out_flag_reg <= res_flag;
        end
        else if (state_reg == ST_DIV && div_res.done)
        begin
            out_data_reg <= div_res.quotient;
            out_flag_reg <= 1'b0;
        end
    end

    assign out_ch.valid                   = out_valid_reg;
    assign out_ch.filtered                = out_data_reg;
    assign out_ch.weight_sum_not_positive = out_flag_reg;

`ifndef ASSERT_OFF
    a_mac_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == ST_RUN || state_reg == ST_FINISH))
        else $error("accumulate outside a query");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (norm_reg && wsum_reg > 0))
        else $error("divider started without a positive weight sum");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUTPUT)
        else $error("result raised outside the output state");
`endif
endmodule
